@@ hw/rtl/mme_pkg.sv @@
// Shared types and constants of the matrix multiply engine.
// No dependencies; imported by the top level.
`default_nettype none

package mme_pkg;

   localparam int VALUE_WIDTH = 16;
   localparam int INDEX_WIDTH = 6;
   localparam int SIZE_WIDTH  = 7;
   localparam int SUM_WIDTH   = 40;
   localparam int PROD_WIDTH  = 2 * VALUE_WIDTH;
   localparam int LIMIT_WIDTH = 9;
   localparam int ADDR_CALC_WIDTH = 17;

   localparam logic [1:0] MODE_LOAD_A = 2'd0;
   localparam logic [1:0] MODE_LOAD_B = 2'd1;
   localparam logic [1:0] MODE_QUERY  = 2'd2;

   localparam logic [1:0] CSR_ROWS_USED  = 2'd0;
   localparam logic [1:0] CSR_INNER_USED = 2'd1;
   localparam logic [1:0] CSR_COLS_USED  = 2'd2;

   localparam logic [SIZE_WIDTH-1:0] SIZE_RESET = 7'd64;

   typedef enum logic [3:0] {
      S_IDLE  = 4'b0001,
      S_RUN   = 4'b0010,
      S_DRAIN = 4'b0100,
      S_DONE  = 4'b1000
   } engine_state_type;

endpackage

`default_nettype wire

@@ hw/rtl/matrix_multiply_engine_top.sv @@
// Top level of the matrix multiply engine: two element stores and one MAC.
// Depends on mme_pkg and mme_ram.
`default_nettype none

// Load words write one element of A or B; a load outside the configured
// sizes is dropped. A query word reads A[row][t] and B[t][col] from the two
// stores once per cycle and feeds one multiplier and a 40-bit accumulator;
// the block stalls new words until the query's result is in the output
// register, and the single read port of each store sets the pace of the
// reads. A query outside the configured sizes returns zero with index_error
// set. The result sits in an output register, so the next word is taken
// while the previous result waits on rsp_stall.
// Store contents are undefined until written and are never cleared.
module matrix_multiply_engine_top
   import mme_pkg::*;
#(
   parameter int MAX_ROWS  = 64,
   parameter int MAX_INNER = 64,
   parameter int MAX_COLS  = 64
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   output logic                               req_stall,
   input  wire logic        [1:0]             req_mode,
   input  wire logic        [INDEX_WIDTH-1:0] req_row,
   input  wire logic        [INDEX_WIDTH-1:0] req_col,
   input  wire logic signed [VALUE_WIDTH-1:0] req_value,
   output logic                               rsp_valid,
   input  wire logic                          rsp_stall,
   output logic signed      [SUM_WIDTH-1:0]   rsp_product_sum,
   output logic             [INDEX_WIDTH-1:0] rsp_out_row,
   output logic             [INDEX_WIDTH-1:0] rsp_out_col,
   output logic                               rsp_index_error,
   input  wire logic                          csr_write_enable,
   input  wire logic        [1:0]             csr_index,
   input  wire logic        [SIZE_WIDTH-1:0]  csr_write_data
);

   localparam int A_DEPTH = MAX_ROWS * MAX_INNER;
   localparam int B_DEPTH = MAX_INNER * MAX_COLS;
   localparam int A_AW = (A_DEPTH > 1) ? $clog2(A_DEPTH) : 1;
   localparam int B_AW = (B_DEPTH > 1) ? $clog2(B_DEPTH) : 1;
   localparam logic [LIMIT_WIDTH-1:0] ROWS_LIMIT  = LIMIT_WIDTH'(MAX_ROWS);
   localparam logic [LIMIT_WIDTH-1:0] INNER_LIMIT = LIMIT_WIDTH'(MAX_INNER);
   localparam logic [LIMIT_WIDTH-1:0] COLS_LIMIT  = LIMIT_WIDTH'(MAX_COLS);
   localparam logic [ADDR_CALC_WIDTH-1:0] INNER_STRIDE = ADDR_CALC_WIDTH'(MAX_INNER);
   localparam logic [ADDR_CALC_WIDTH-1:0] COLS_STRIDE  = ADDR_CALC_WIDTH'(MAX_COLS);

   engine_state_type state_ff, state_in;

   logic [SIZE_WIDTH-1:0]  rows_used_ff, inner_used_ff, cols_used_ff;
   logic [LIMIT_WIDTH-1:0] rows_eff, inner_eff, cols_eff;
   logic [LIMIT_WIDTH-1:0] row_wide, col_wide;

   logic [INDEX_WIDTH-1:0] q_row_ff, q_col_ff;
   logic                   q_err_ff;
   logic [LIMIT_WIDTH-1:0] step_ff;
   logic                   rd_valid_ff, prod_valid_ff;
   logic signed [PROD_WIDTH-1:0] prod_ff;
   logic signed [SUM_WIDTH-1:0]  acc_ff;

   logic                   rsp_valid_ff;
   logic signed [SUM_WIDTH-1:0] rsp_sum_ff;
   logic [INDEX_WIDTH-1:0] rsp_row_ff, rsp_col_ff;
   logic                   rsp_err_ff;

   logic req_accept, query_accept, query_error, last_step, out_load;
   logic a_write, b_write;
   logic [ADDR_CALC_WIDTH-1:0] a_wr_full, b_wr_full, a_rd_full, b_rd_full;
   logic [VALUE_WIDTH-1:0] a_rd_data, b_rd_data;

   always_comb begin
      rows_eff  = ({2'b00, rows_used_ff} > ROWS_LIMIT) ? ROWS_LIMIT : {2'b00, rows_used_ff};
      inner_eff = ({2'b00, inner_used_ff} > INNER_LIMIT) ? INNER_LIMIT
                                                          : {2'b00, inner_used_ff};
      cols_eff  = ({2'b00, cols_used_ff} > COLS_LIMIT) ? COLS_LIMIT : {2'b00, cols_used_ff};
   end

   assign row_wide = {3'b000, req_row};
   assign col_wide = {3'b000, req_col};

   assign req_stall    = (state_ff != S_IDLE);
   assign req_accept   = req_valid && !req_stall;
   assign query_accept = req_accept && (req_mode == MODE_QUERY);
   assign query_error  = (row_wide >= rows_eff) || (col_wide >= cols_eff);
   assign a_write = req_accept && (req_mode == MODE_LOAD_A)
                    && (row_wide < rows_eff) && (col_wide < inner_eff);
   assign b_write = req_accept && (req_mode == MODE_LOAD_B)
                    && (row_wide < inner_eff) && (col_wide < cols_eff);
   assign last_step = ((step_ff + 9'd1) == inner_eff);
   assign out_load  = (state_ff == S_DONE) && (!rsp_valid_ff || !rsp_stall);

   assign a_wr_full = {11'd0, req_row} * INNER_STRIDE + {11'd0, req_col};
   assign b_wr_full = {11'd0, req_row} * COLS_STRIDE + {11'd0, req_col};
   assign a_rd_full = {11'd0, q_row_ff} * INNER_STRIDE + {8'd0, step_ff};
   assign b_rd_full = {8'd0, step_ff} * COLS_STRIDE + {11'd0, q_col_ff};

   mme_ram #(
      .WIDTH (VALUE_WIDTH),
      .DEPTH (A_DEPTH),
      .AW    (A_AW)
   ) u_left_store (
      .clock         (clock),
      .write_enable  (a_write),
      .write_address (a_wr_full[A_AW-1:0]),
      .write_data    (req_value),
      .read_address  (a_rd_full[A_AW-1:0]),
      .read_data     (a_rd_data)
   );

   mme_ram #(
      .WIDTH (VALUE_WIDTH),
      .DEPTH (B_DEPTH),
      .AW    (B_AW)
   ) u_right_store (
      .clock         (clock),
      .write_enable  (b_write),
      .write_address (b_wr_full[B_AW-1:0]),
      .write_data    (req_value),
      .read_address  (b_rd_full[B_AW-1:0]),
      .read_data     (b_rd_data)
   );

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (query_accept) begin
               if (query_error) begin
                  state_in = S_DONE;
               end else if (inner_eff == 9'd0) begin
                  state_in = S_DRAIN;
               end else begin
                  state_in = S_RUN;
               end
            end
         end
         S_RUN: begin
            if (last_step) begin
               state_in = S_DRAIN;
            end
         end
         S_DRAIN: begin
            if (!rd_valid_ff && !prod_valid_ff) begin
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            if (out_load) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         rows_used_ff  <= SIZE_RESET;
         inner_used_ff <= SIZE_RESET;
         cols_used_ff  <= SIZE_RESET;
         rd_valid_ff   <= 1'b0;
         prod_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         rd_valid_ff   <= (state_ff == S_RUN);
         prod_valid_ff <= rd_valid_ff;
         if (out_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
         if (csr_write_enable) begin
            case (csr_index)
               CSR_ROWS_USED:  rows_used_ff  <= csr_write_data;
               CSR_INNER_USED: inner_used_ff <= csr_write_data;
               CSR_COLS_USED:  cols_used_ff  <= csr_write_data;
               default: begin
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (query_accept) begin
         q_row_ff <= req_row;
         q_col_ff <= req_col;
         q_err_ff <= query_error;
         step_ff  <= '0;
         acc_ff   <= '0;
      end else begin
         if (state_ff == S_RUN) begin
            step_ff <= step_ff + 9'd1;
         end
         if (prod_valid_ff) begin
            acc_ff <= acc_ff + {{(SUM_WIDTH - PROD_WIDTH){prod_ff[PROD_WIDTH-1]}}, prod_ff};
         end
      end
      prod_ff <= $signed(a_rd_data) * $signed(b_rd_data);
      if (out_load) begin
         rsp_sum_ff <= q_err_ff ? '0 : acc_ff;
         rsp_row_ff <= q_row_ff;
         rsp_col_ff <= q_col_ff;
         rsp_err_ff <= q_err_ff;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_product_sum = rsp_sum_ff;
   assign rsp_out_row     = rsp_row_ff;
   assign rsp_out_col     = rsp_col_ff;
   assign rsp_index_error = rsp_err_ff;

endmodule

`default_nettype wire

@@ hw/rtl/mme_ram.sv @@
// Generic single-clock RAM with one write port and one registered read port.
// No dependencies; instantiated for both matrix stores.
`default_nettype none

module mme_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 4096,
   parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic             clock,
   input  wire logic             write_enable,
   input  wire logic [AW-1:0]    write_address,
   input  wire logic [WIDTH-1:0] write_data,
   input  wire logic [AW-1:0]    read_address,
   output logic      [WIDTH-1:0] read_data
);

   logic [WIDTH-1:0] storage_ff [DEPTH];
   logic [WIDTH-1:0] read_data_ff;

   always_ff @(posedge clock) begin
      if (write_enable) begin
         storage_ff[write_address] <= write_data;
      end
      read_data_ff <= storage_ff[read_address];
   end

   assign read_data = read_data_ff;

endmodule

`default_nettype wire
